>>> rtl/isma_pkg.sv
// Shared types, constants and codes of the IMU sample scaler and moving-average filter.
`default_nettype none
package isma_pkg;

	// Field widths
	localparam int CH_W      = 3;
	localparam int SAMPLE_W  = 16;
	localparam int VALUE_W   = 32;
	localparam int AVG_CNT_W = 4;
	localparam int PROD_W    = SAMPLE_W + VALUE_W;

	// Channel map
	localparam int NUM_CH = 7;
	localparam logic [CH_W-1:0] GYRO_FIRST_CH = 3'd3;
	localparam logic [CH_W-1:0] TEMP_CH       = 3'd6;
	localparam logic [CH_W-1:0] NO_CH         = 3'd7;

	// Filter window
	localparam int WINDOW_DEF = 8;

	// Quotient bits resolved per divider cycle
	localparam int DIV_STEP_BITS = 4;

	// Configuration registers
	localparam int CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ACCEL_GAIN  = 2'd0,
		REG_GYRO_GAIN   = 2'd1,
		REG_TEMP_GAIN   = 2'd2,
		REG_TEMP_OFFSET = 2'd3
	} isma_cfg_reg_t;

	localparam logic [VALUE_W-1:0] ACCEL_GAIN_RST  = 32'd262081;
	localparam logic [VALUE_W-1:0] GYRO_GAIN_RST   = 32'd4574140;
	localparam logic [VALUE_W-1:0] TEMP_GAIN_RST   = 32'd13142495;
	localparam logic [VALUE_W-1:0] TEMP_OFFSET_RST = 32'd1638400;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;
		logic mul;
		logic scale;
		logic update;
		logic div_load;
		logic div_step;
		logic out_load;
	} isma_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic div_last;
	} isma_sts_t;

endpackage
`default_nettype wire

>>> rtl/isma_div.sv
// Multi-cycle unsigned divider for the window sum by the sample count.
`default_nettype none
module isma_div #(
	parameter int WINDOW = isma_pkg::WINDOW_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 load,
	input  logic                                 step,
	input  logic [isma_pkg::VALUE_W+$clog2(WINDOW)-1:0] dividend,
	input  logic [$clog2(WINDOW+1)-1:0]          divisor,
	output logic [isma_pkg::VALUE_W+$clog2(WINDOW)-1:0] quotient,
	output logic                                 last
);
	import isma_pkg::*;

	localparam int SUM_W      = VALUE_W + $clog2(WINDOW);
	localparam int CNT_W      = $clog2(WINDOW + 1);
	localparam int DIV_CYCLES = (SUM_W + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
	localparam int DIV_W      = DIV_CYCLES * DIV_STEP_BITS;
	localparam int ITER_W     = $clog2(DIV_CYCLES);

	logic [CNT_W-1:0]  rem_q;
	logic [DIV_W-1:0]  quo_q;
	logic [CNT_W-1:0]  divisor_q;
	logic [ITER_W-1:0] iter_q;
	logic [CNT_W-1:0]  rem_nxt;
	logic [DIV_W-1:0]  quo_nxt;

	// Restoring division, DIV_STEP_BITS quotient bits per cycle while step is high
	always_comb begin
		logic [CNT_W:0] trial;
		rem_nxt = rem_q;
		quo_nxt = quo_q;
		for (int i = 0; i < DIV_STEP_BITS; i++) begin
			trial   = {rem_nxt, quo_nxt[DIV_W-1]};
			quo_nxt = {quo_nxt[DIV_W-2:0], 1'b0};
			if (trial >= {1'b0, divisor_q}) begin
				rem_nxt    = CNT_W'(trial - {1'b0, divisor_q});
				quo_nxt[0] = 1'b1;
			end else begin
				rem_nxt = trial[CNT_W-1:0];
			end
		end
	end

	// Operand and partial result registers
	always_ff @(posedge clk) begin
		if (load) begin
			rem_q     <= '0;
			quo_q     <= DIV_W'(dividend);
			divisor_q <= divisor;
		end else if (step) begin
			rem_q <= rem_nxt;
			quo_q <= quo_nxt;
		end
	end

	// Iteration count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= '0;
		end else if (load) begin
			iter_q <= '0;
		end else if (step) begin
			iter_q <= iter_q + 1'b1;
		end
	end

	assign last     = (iter_q == ITER_W'(DIV_CYCLES - 1));
	assign quotient = quo_q[SUM_W-1:0];

	// Partial remainder stays below the divisor
	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> (rem_q < divisor_q))
		else $error("divider remainder not below divisor");

endmodule
`default_nettype wire

>>> rtl/isma_dp.sv
// Datapath: config registers, scaling, window memory, running sums and output register.
`default_nettype none
module isma_dp #(
	parameter int WINDOW = isma_pkg::WINDOW_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  isma_pkg::isma_cmd_t               cmd,
	output isma_pkg::isma_sts_t               sts,
	input  logic                              cfg_wr_en,
	input  logic [isma_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [isma_pkg::VALUE_W-1:0]      cfg_data,
	input  logic [isma_pkg::CH_W-1:0]         channel,
	input  logic signed [isma_pkg::SAMPLE_W-1:0] raw_sample,
	output logic [isma_pkg::CH_W-1:0]         channel_out,
	output logic signed [isma_pkg::VALUE_W-1:0] filtered_value,
	output logic [isma_pkg::AVG_CNT_W-1:0]    samples_averaged
);
	import isma_pkg::*;

	localparam int SUM_W  = VALUE_W + $clog2(WINDOW);
	localparam int CNT_W  = $clog2(WINDOW + 1);
	localparam int POS_W  = $clog2(WINDOW);
	localparam int DEPTH  = NUM_CH * WINDOW;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam logic [CNT_W-1:0]  WIN_C    = CNT_W'(WINDOW);
	localparam logic [POS_W-1:0]  POS_LAST = POS_W'(WINDOW - 1);
	localparam logic [ADDR_W-1:0] WIN_A    = ADDR_W'(WINDOW);

	// Configuration registers
	logic [VALUE_W-1:0]        accel_gain_q;
	logic [VALUE_W-1:0]        gyro_gain_q;
	logic [VALUE_W-1:0]        temp_gain_q;
	logic signed [VALUE_W-1:0] temp_offset_q;

	// Per-channel state
	logic [POS_W-1:0]        pos_q  [0:NUM_CH-1];
	logic [CNT_W-1:0]        fill_q [0:NUM_CH-1];
	logic signed [SUM_W-1:0] sum_q  [0:NUM_CH-1];

	// Window memory
	logic signed [VALUE_W-1:0] mem [0:DEPTH-1];
	logic signed [VALUE_W-1:0] mem_rd_q;
	logic [ADDR_W-1:0]         addr;

	// Item registers
	logic [CH_W-1:0]           ch_q;
	logic signed [SAMPLE_W-1:0] raw_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [VALUE_W-1:0] val_q;

	logic [VALUE_W-1:0]        gain;
	logic signed [VALUE_W:0]   scaled_ext;
	logic signed [VALUE_W-1:0] val_nxt;
	logic signed [VALUE_W-1:0] old_val;
	logic signed [SUM_W-1:0]   sum_nxt;
	logic [CNT_W-1:0]          fill_nxt;
	logic [POS_W-1:0]          pos_nxt;
	logic [SUM_W-1:0]          sum_mag;
	logic [SUM_W-1:0]          quotient;
	logic [VALUE_W:0]          quo_mag;
	logic                      neg_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_gain_q  <= ACCEL_GAIN_RST;
			gyro_gain_q   <= GYRO_GAIN_RST;
			temp_gain_q   <= TEMP_GAIN_RST;
			temp_offset_q <= TEMP_OFFSET_RST;
		end else if (cfg_wr_en) begin
			case (isma_cfg_reg_t'(cfg_index))
				REG_ACCEL_GAIN:  accel_gain_q  <= cfg_data;
				REG_GYRO_GAIN:   gyro_gain_q   <= cfg_data;
				REG_TEMP_GAIN:   temp_gain_q   <= cfg_data;
				REG_TEMP_OFFSET: temp_offset_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Gain by channel type
	always_comb begin
		if (ch_q < GYRO_FIRST_CH) begin
			gain = accel_gain_q;
		end else if (ch_q < TEMP_CH) begin
			gain = gyro_gain_q;
		end else begin
			gain = temp_gain_q;
		end
	end

	// Floor shift by 16, temperature offset, saturation to 32 bits
	always_comb begin
		scaled_ext = {prod_q[PROD_W-1], prod_q[PROD_W-1:16]};
		if (ch_q == TEMP_CH) begin
			scaled_ext = scaled_ext + {temp_offset_q[VALUE_W-1], temp_offset_q};
		end
		if (scaled_ext[VALUE_W] != scaled_ext[VALUE_W-1]) begin
			val_nxt = scaled_ext[VALUE_W] ? {1'b1, {(VALUE_W-1){1'b0}}}
			                              : {1'b0, {(VALUE_W-1){1'b1}}};
		end else begin
			val_nxt = scaled_ext[VALUE_W-1:0];
		end
	end

	// Slot address of the current channel
	assign addr = ch_q * WIN_A + ADDR_W'(pos_q[ch_q]);

	// Window update; slots not yet written during warm-up read as zero
	always_comb begin
		old_val  = (fill_q[ch_q] < WIN_C) ? '0 : mem_rd_q;
		sum_nxt  = sum_q[ch_q] - SUM_W'(old_val) + SUM_W'(val_q);
		fill_nxt = (fill_q[ch_q] < WIN_C) ? fill_q[ch_q] + 1'b1 : fill_q[ch_q];
		pos_nxt  = (pos_q[ch_q] == POS_LAST) ? '0 : pos_q[ch_q] + 1'b1;
		sum_mag  = sum_q[ch_q][SUM_W-1] ? SUM_W'(-sum_q[ch_q]) : SUM_W'(sum_q[ch_q]);
	end

	// Item pipeline registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ch_q  <= channel;
			raw_q <= raw_sample;
		end
		if (cmd.mul) begin
			prod_q <= PROD_W'($signed({{VALUE_W{raw_q[SAMPLE_W-1]}}, raw_q})
			          * $signed({{SAMPLE_W{1'b0}}, gain}));
		end
		if (cmd.scale) begin
			val_q <= val_nxt;
		end
		if (cmd.div_load) begin
			neg_q <= sum_q[ch_q][SUM_W-1];
		end
	end

	// Window memory
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			mem[addr] <= val_q;
		end
		if (cmd.mul) begin
			mem_rd_q <= mem[addr];
		end
	end

	// Per-channel pointers, counts and sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CH; i++) begin
				pos_q[i]  <= '0;
				fill_q[i] <= '0;
				sum_q[i]  <= '0;
			end
		end else if (cmd.update) begin
			pos_q[ch_q]  <= pos_nxt;
			fill_q[ch_q] <= fill_nxt;
			sum_q[ch_q]  <= sum_nxt;
		end
	end

	isma_div #(
		.WINDOW (WINDOW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (cmd.div_load),
		.step     (cmd.div_step),
		.dividend (sum_mag),
		.divisor  (fill_q[ch_q]),
		.quotient (quotient),
		.last     (sts.div_last)
	);

	// Average magnitude never exceeds 2^31, so the signed result fits 32 bits
	assign quo_mag = quotient[VALUE_W:0];

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			channel_out      <= ch_q;
			filtered_value   <= neg_q ? VALUE_W'(-quo_mag) : VALUE_W'(quo_mag);
			samples_averaged <= AVG_CNT_W'(fill_q[ch_q]);
		end
	end

	// Count after an update lies in 1..WINDOW
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |=> (fill_q[ch_q] != '0 && fill_q[ch_q] <= WIN_C))
		else $error("fill count out of range");

endmodule
`default_nettype wire

>>> rtl/isma_ctrl.sv
// Controller: sequences one transaction through scale, window update, divide and output.
`default_nettype none
module isma_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [isma_pkg::CH_W-1:0] in_channel,
	output logic                      in_stall,
	output logic                      out_valid,
	input  logic                      out_stall,
	output isma_pkg::isma_cmd_t       cmd,
	input  isma_pkg::isma_sts_t       sts
);
	import isma_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SCALE,
		ST_UPDATE,
		ST_DIV_LOAD,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	// Command decode
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE:     cmd.capture  = in_valid && (in_channel != NO_CH);
			ST_MUL:      cmd.mul      = 1'b1;
			ST_SCALE:    cmd.scale    = 1'b1;
			ST_UPDATE:   cmd.update   = 1'b1;
			ST_DIV_LOAD: cmd.div_load = 1'b1;
			ST_DIV:      cmd.div_step = 1'b1;
			ST_DONE:     cmd.out_load = out_free;
			default: ;
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.capture) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL:      state_q <= ST_SCALE;
				ST_SCALE:    state_q <= ST_UPDATE;
				ST_UPDATE:   state_q <= ST_DIV_LOAD;
				ST_DIV_LOAD: state_q <= ST_DIV;
				ST_DIV: begin
					if (sts.div_last) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("output register overwritten");

	// Divider is loaded right after the window update
	a_update_then_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |=> cmd.div_load)
		else $error("divider not loaded after update");

	// A transaction is only taken with the controller idle, and the multiply state follows without an output load
	a_capture_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (state_q == ST_MUL && !cmd.out_load))
		else $error("capture out of sequence");

endmodule
`default_nettype wire

>>> rtl/imu_sample_scale_moving_average_unit.sv
// Top level of the IMU sample scaler with per-channel moving-average filter.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------------------
//  in       | sink      | in_valid/in_stall  | channel, raw_sample
//  out      | source    | out_valid/out_stall| channel_out, filtered_value, samples_averaged
//  cfg      | sink      | cfg_wr_en          | cfg_index, cfg_data
//
// One transaction passes from acceptance through multiply, scale, window update, divider
// load, divide and done states to output load; the next is accepted after that load at the
// earliest. The divider, four quotient bits a cycle, dominates.
// A transaction on channel seven is accepted and dropped without a result.
// Reset clears config to defaults, all sums, counts and pointers; window slots need no
// clearing since slots not yet written are read as zero while a channel fills.
// A result stalled at the output holds the next transaction in its final (done) state only.
`default_nettype none
module imu_sample_scale_moving_average_unit #(
	parameter int WINDOW = isma_pkg::WINDOW_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [isma_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [isma_pkg::VALUE_W-1:0]         cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [isma_pkg::CH_W-1:0]            channel,
	input  logic signed [isma_pkg::SAMPLE_W-1:0] raw_sample,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [isma_pkg::CH_W-1:0]            channel_out,
	output logic signed [isma_pkg::VALUE_W-1:0]  filtered_value,
	output logic [isma_pkg::AVG_CNT_W-1:0]       samples_averaged
);
	import isma_pkg::*;

	isma_cmd_t cmd;
	isma_sts_t sts;

	isma_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_channel (channel),
		.in_stall   (in_stall),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.cmd        (cmd),
		.sts        (sts)
	);

	isma_dp #(
		.WINDOW (WINDOW)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.channel          (channel),
		.raw_sample       (raw_sample),
		.channel_out      (channel_out),
		.filtered_value   (filtered_value),
		.samples_averaged (samples_averaged)
	);

endmodule
`default_nettype wire
